/* rtl/ilsat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inclusive LRU tag store: shared definitions
// Geometry of the tag store, derived widths and the records that pass from
// the front end to the back end.
// ----------------------------------------------------------------------------
package ilsat_pkg;

	localparam int SETS      = 1024;
	localparam int WAYS      = 8;
	localparam int ADDR_BITS = 40;

	localparam int FIELD_W = 40;
	localparam int TAG_W   = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W  = WAY_W;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [SET_W-1:0] set_idx;
		logic             instr;
	} acc_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

endpackage

/* rtl/ilsat_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Access request channel
// Carries one cache access: the block address and its category.
// ----------------------------------------------------------------------------
interface ilsat_req_if import ilsat_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] block_addr;
	logic               is_instruction;

	modport source (output valid, block_addr, is_instruction, input ready);
	modport sink   (input valid, block_addr, is_instruction, output ready);

endinterface

/* rtl/ilsat_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Access response channel
// Carries the outcome of one access and any back-invalidation it requires.
// ----------------------------------------------------------------------------
interface ilsat_rsp_if import ilsat_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               hit;
	logic               evicted;
	logic [FIELD_W-1:0] victim_addr;
	logic               invalidate_instr_l1;

	modport source (output valid, hit, evicted, victim_addr, invalidate_instr_l1,
		input ready);
	modport sink   (input valid, hit, evicted, victim_addr, invalidate_instr_l1,
		output ready);

endinterface

/* rtl/inclusive_lru_set_assoc_tags_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inclusive LRU set-associative tag store
// Second-level tag store with true LRU replacement that reports evicted
// lines for back-invalidation of the instruction or data first-level cache.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req     | in        | block_addr, is_instruction
//  rsp     | out       | hit, evicted, victim_addr, invalidate_instr_l1
//
//  In the back end each access first reads its set from the tag and recency
//  arrays, then is resolved and its set is written back.
//  After reset a clearing pass over all SETS sets (1024) zeroes the valid and
//  recency arrays; no request is taken during it.
//  A two-entry queue sits between front and back end; a held response stalls
//  the back end until it is taken, and the input too once the queue is full.
// ----------------------------------------------------------------------------
module inclusive_lru_set_assoc_tags_top import ilsat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ilsat_req_if.sink   req,
	ilsat_rsp_if.source rsp
);

	acc_t       head;
	logic       head_valid;
	back_stat_t stat;

	ilsat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.stat       (stat),
		.head       (head),
		.head_valid (head_valid)
	);

	ilsat_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.stat       (stat),
		.rsp        (rsp)
	);

endmodule

/* rtl/ilsat_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inclusive LRU tag store: front end
// Accepts accesses, reduces the address to tag and set index, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module ilsat_front import ilsat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ilsat_req_if.sink   req,
	input  back_stat_t  stat,
	output acc_t        head,
	output logic        head_valid
);

	acc_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	acc_t              acc_in;
	logic              push;
	logic              pop;

	always_comb begin
		acc_in.tag     = TAG_W'(req.block_addr);
		acc_in.set_idx = SET_W'(acc_in.tag & TAG_W'(SETS - 1));
		acc_in.instr   = req.is_instruction;
	end

	assign req.ready  = (count_q != QCNT_W'(QDEPTH)) && !stat.clearing;
	assign push       = req.valid && req.ready;
	assign pop        = stat.pop && head_valid;
	assign head_valid = (count_q != '0);
	assign head       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= acc_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/ilsat_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inclusive LRU tag store: back end
// Holds the tag and recency arrays, reads one set per access, resolves hit,
// fill or eviction, writes the set back and registers the response.
// ----------------------------------------------------------------------------
module ilsat_back import ilsat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  acc_t        head,
	input  logic        head_valid,
	output back_stat_t  stat,
	ilsat_rsp_if.source rsp
);

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef struct packed {
		logic [WAYS-1:0]             valid;
		logic [WAYS-1:0][RANK_W-1:0] rank;
	} meta_row_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_READ   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	tag_row_t   tag_mem  [SETS];
	meta_row_t  meta_mem [SETS];

	state_t          state_q;
	logic [SET_W-1:0] clr_idx_q;
	acc_t            cur_q;
	tag_row_t        tag_rd_q;
	meta_row_t       meta_rd_q;

	logic               out_valid_q;
	logic               hit_q;
	logic               evicted_q;
	logic [FIELD_W-1:0] victim_q;
	logic               inv_instr_q;

	logic             rd_en;
	logic             do_update;
	logic             out_free;
	logic [WAYS-1:0]  hit_vec;
	logic [WAYS-1:0]  free_vec;
	logic [WAYS-1:0]  old_vec;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] vic_way;
	logic [WAY_W-1:0] sel_way;
	logic             hit_any;
	logic             free_any;
	logic [RANK_W:0]  old_rank;
	meta_row_t        meta_new;
	tag_row_t         tag_new;
	logic             meta_we;
	logic [SET_W-1:0] meta_wa;
	meta_row_t        meta_wd;

	assign out_free  = !out_valid_q || rsp.ready;
	assign rd_en     = (state_q == ST_READ) && head_valid;
	assign do_update = (state_q == ST_UPDATE) && out_free;

	assign stat.pop      = rd_en;
	assign stat.clearing = (state_q == ST_CLEAR);

	always_comb begin
		hit_vec  = '0;
		free_vec = '0;
		old_vec  = '0;
		for (int j = 0; j < WAYS; j++) begin
			hit_vec[j]  = meta_rd_q.valid[j] && (tag_rd_q[j] == cur_q.tag);
			free_vec[j] = !meta_rd_q.valid[j];
			old_vec[j]  = (meta_rd_q.rank[j] == RANK_W'(WAYS - 1));
		end
		hit_any  = |hit_vec;
		free_any = |free_vec;
		hit_way  = '0;
		free_way = '0;
		vic_way  = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_way = WAY_W'(j);
			end
			if (free_vec[j]) begin
				free_way = WAY_W'(j);
			end
			if (old_vec[j]) begin
				vic_way = WAY_W'(j);
			end
		end
	end

	always_comb begin
		if (hit_any) begin
			sel_way  = hit_way;
			old_rank = {1'b0, meta_rd_q.rank[hit_way]};
		end else if (free_any) begin
			sel_way  = free_way;
			old_rank = (RANK_W + 1)'(WAYS);
		end else begin
			sel_way  = vic_way;
			old_rank = {1'b0, meta_rd_q.rank[vic_way]};
		end
		meta_new = meta_rd_q;
		tag_new  = tag_rd_q;
		for (int j = 0; j < WAYS; j++) begin
			if (WAY_W'(j) == sel_way) begin
				meta_new.valid[j] = 1'b1;
				meta_new.rank[j]  = '0;
				tag_new[j]        = cur_q.tag;
			end else if (meta_rd_q.valid[j] && ({1'b0, meta_rd_q.rank[j]} < old_rank)) begin
				meta_new.rank[j] = meta_rd_q.rank[j] + RANK_W'(1);
			end
		end
	end

	always_comb begin
		meta_we = 1'b0;
		meta_wa = cur_q.set_idx;
		meta_wd = meta_new;
		if (state_q == ST_CLEAR) begin
			meta_we = 1'b1;
			meta_wa = clr_idx_q;
			meta_wd = '0;
		end else if (do_update) begin
			meta_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[head.set_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (do_update && !hit_any) begin
			tag_mem[cur_q.set_idx] <= tag_new;
		end
		if (rd_en) begin
			tag_rd_q <= tag_mem[head.set_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= head;
		end
		if (do_update) begin
			hit_q       <= hit_any;
			evicted_q   <= !hit_any && !free_any;
			victim_q    <= (!hit_any && !free_any) ? FIELD_W'(tag_rd_q[vic_way]) : '0;
			inv_instr_q <= !hit_any && !free_any && cur_q.instr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_update) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SET_W'(1);
					if (clr_idx_q == SET_W'(SETS - 1)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (rd_en) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (do_update) begin
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign rsp.valid               = out_valid_q;
	assign rsp.hit                 = hit_q;
	assign rsp.evicted             = evicted_q;
	assign rsp.victim_addr         = victim_q;
	assign rsp.invalidate_instr_l1 = inv_instr_q;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inclusive LRU tag store testbench
// Drives cache accesses through the request channel and checks every
// response against a behavioural copy of the set-associative tag store with
// true LRU replacement: hit, eviction, victim address and L1 choice. Runs a
// directed part, random traffic under several idling patterns, and a long
// receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

	import ilsat_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LINES       = SETS * WAYS;

	typedef struct {
		logic               hit;
		logic               evicted;
		logic [FIELD_W-1:0] victim_addr;
		logic               invalidate_instr_l1;
	} access_outcome_t;

	logic clk;
	logic arst_n;

	ilsat_req_if req ();
	ilsat_rsp_if rsp ();

	inclusive_lru_set_assoc_tags_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [TAG_W-1:0] line_tag_model [LINES];
	bit               line_valid_model [LINES];
	int unsigned      line_age_model [LINES];

	access_outcome_t expected_outcomes [$];

	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          send_gap_pct   = 0;
	int          rsp_stall_pct  = 0;
	int          rsp_hold_left  = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic void refresh_way(int base, int way, int unsigned old_age);
		for (int j = 0; j < WAYS; j++) begin
			if (j != way && line_valid_model[base + j] && line_age_model[base + j] < old_age)
				line_age_model[base + j]++;
		end
		line_age_model[base + way] = 0;
	endfunction

	function automatic access_outcome_t predict_access(logic [FIELD_W-1:0] addr_in,
		logic instr);
		access_outcome_t  o;
		logic [TAG_W-1:0] addr;
		int               base;
		int               victim;
		int unsigned      oldest;
		o.hit                 = 1'b0;
		o.evicted             = 1'b0;
		o.victim_addr         = '0;
		o.invalidate_instr_l1 = 1'b0;
		addr = addr_in[TAG_W-1:0];
		base = int'(addr % TAG_W'(SETS)) * WAYS;
		for (int j = 0; j < WAYS; j++) begin
			if (line_valid_model[base + j] && line_tag_model[base + j] == addr) begin
				refresh_way(base, j, line_age_model[base + j]);
				o.hit = 1'b1;
				return o;
			end
		end
		for (int j = 0; j < WAYS; j++) begin
			if (!line_valid_model[base + j]) begin
				refresh_way(base, j, WAYS);
				line_tag_model[base + j]   = addr;
				line_valid_model[base + j] = 1'b1;
				return o;
			end
		end
		victim = 0;
		oldest = line_age_model[base];
		for (int j = 1; j < WAYS; j++) begin
			if (line_age_model[base + j] > oldest) begin
				oldest = line_age_model[base + j];
				victim = j;
			end
		end
		o.evicted             = 1'b1;
		o.victim_addr         = FIELD_W'(line_tag_model[base + victim]);
		o.invalidate_instr_l1 = instr;
		refresh_way(base, victim, oldest);
		line_tag_model[base + victim] = addr;
		return o;
	endfunction

	function automatic logic [FIELD_W-1:0] random_addr();
		logic [FIELD_W-1:0] upper;
		logic [FIELD_W-1:0] set_part;
		int unsigned        pick;
		int unsigned        idx;
		int unsigned        hot;
		pick = $urandom_range(99);
		idx  = $urandom_range(11);
		if (pick >= 80)
			return FIELD_W'({$urandom(), $urandom()});
		upper = FIELD_W'(idx);
		if (idx[0])
			upper = ~upper;
		if (pick < 55) begin
			hot = $urandom_range(2);
			set_part = (hot == 0) ? '0 : (hot == 1) ? FIELD_W'(5 % SETS) : FIELD_W'(SETS - 1);
		end else begin
			set_part = FIELD_W'($urandom_range(SETS - 1));
		end
		return upper * FIELD_W'(SETS) + set_part;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_access(input logic [FIELD_W-1:0] addr, input logic instr);
		while ($urandom_range(99) < send_gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid          <= 1'b1;
		req.block_addr     <= addr;
		req.is_instruction <= instr;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		expected_outcomes.push_back(predict_access(addr, instr));
	endtask

	task automatic pause_requests();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_left > 0) begin
				rsp.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_responses
		access_outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("response with no access outstanding", 64'd0, 64'd0);
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp.hit !== want.hit)
					report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", 64'(rsp.evicted), 64'(want.evicted));
				if (rsp.victim_addr !== want.victim_addr)
					report_mismatch("victim_addr", 64'(rsp.victim_addr),
						64'(want.victim_addr));
				if (rsp.invalidate_instr_l1 !== want.invalidate_instr_l1)
					report_mismatch("invalidate_instr_l1", 64'(rsp.invalidate_instr_l1),
						64'(want.invalidate_instr_l1));
			end
		end
	end

	task automatic test_address_extremes();
		logic [FIELD_W-1:0] top;
		top = '1;
		send_access('0, 1'b0);
		send_access('0, 1'b1);
		send_access(top, 1'b1);
		send_access(top, 1'b0);
	endtask

	task automatic test_fill_and_evict();
		logic [FIELD_W-1:0] base_set;
		logic [FIELD_W-1:0] top;
		base_set = FIELD_W'(3 % SETS);
		top      = '1;
		for (int i = 1; i <= WAYS; i++)
			send_access(FIELD_W'(i) * FIELD_W'(SETS) + base_set, i[0]);
		send_access(FIELD_W'(WAYS + 1) * FIELD_W'(SETS) + base_set, 1'b1);
		send_access(FIELD_W'(4) * FIELD_W'(SETS) + base_set, 1'b0);
		send_access(FIELD_W'(WAYS + 2) * FIELD_W'(SETS) + base_set, 1'b0);
		send_access(FIELD_W'(1) * FIELD_W'(SETS) + base_set, 1'b1);
		for (int i = 1; i < WAYS; i++)
			send_access(top - FIELD_W'(i) * FIELD_W'(SETS), 1'b0);
		send_access(FIELD_W'(SETS - 1), 1'b1);
		pause_requests();
	endtask

	task automatic test_random_traffic(input int count, input int gap_pct,
		input int stall_pct);
		send_gap_pct  = gap_pct;
		rsp_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			send_access(random_addr(), 1'($urandom_range(1)));
		pause_requests();
	endtask

	task automatic test_output_backpressure();
		send_gap_pct  = 0;
		rsp_stall_pct = 0;
		rsp_hold_left = 300;
		for (int i = 0; i < 30; i++)
			send_access(random_addr(), 1'($urandom_range(1)));
		pause_requests();
	endtask

	initial begin
		arst_n             <= 1'b0;
		req.valid          <= 1'b0;
		req.block_addr     <= '0;
		req.is_instruction <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_address_extremes();
		test_fill_and_evict();
		test_random_traffic(330, 0, 0);
		test_random_traffic(330, 46, 0);
		test_random_traffic(330, 0, 46);
		test_random_traffic(330, 37, 37);
		test_output_backpressure();

		send_gap_pct  = 0;
		rsp_stall_pct = 0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* inclusive_lru_set_assoc_tags_top.f */
rtl/ilsat_pkg.sv
rtl/ilsat_req_if.sv
rtl/ilsat_rsp_if.sv
rtl/ilsat_front.sv
rtl/ilsat_back.sv
rtl/inclusive_lru_set_assoc_tags_top.sv
sim/testbench.sv
